/* sv/tra_pkg.sv */
// Shared types, codes, constants and lookup functions of the tile region allocator.
package tra_pkg;

    // Field widths of the request and result items.
    localparam int OP_W      = 2;
    localparam int TYPE_W    = 4;
    localparam int PITCH_W   = 16;
    localparam int HEIGHT_W  = 14;
    localparam int MASK_W    = 8;
    localparam int ADDR_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int ALIGN_W   = 14;
    localparam int SIZE_W    = 32;
    localparam int ACTION_W  = 2;
    localparam int TIDX_W    = 3;

    // Height rounded up to whole 32-line blocks fits in this many bits.
    localparam int HBLK_SHIFT = 5;
    localparam int HBLK_W     = HEIGHT_W + 1 - HBLK_SHIFT;
    localparam int PROD_W     = PITCH_W + HBLK_W;

    // Default number of tile regions.
    localparam int TILE_REGIONS_DEF = 8;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_BIND  = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_BADARG = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOFREE = 2'd2;

    // Tile actions.
    localparam logic [ACTION_W-1:0] ACT_NONE  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PROG  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_INVAL = 2'd2;

    // Alignment of a tiled surface and of a bound region (16K).
    localparam logic [ALIGN_W-1:0] ALIGN_TILED = 14'h3fff;

    // Number of known memory types.
    localparam logic [TYPE_W-1:0] NUM_TYPES = 4'd12;

    // Largest pitch of the ladder; any request above the step below it lands here.
    localparam logic [PITCH_W-1:0] PITCH_TOP = 16'hE000;
    localparam int LADDER_N = 22;
    localparam logic [PITCH_W-1:0] PITCH_LADDER [LADDER_N] = '{
        16'h0200, 16'h0400, 16'h0600, 16'h0800, 16'h0A00, 16'h0C00, 16'h0E00, 16'h1000,
        16'h1400, 16'h1800, 16'h1C00, 16'h2000, 16'h2800, 16'h3000, 16'h3800, 16'h4000,
        16'h5000, 16'h6000, 16'h7000, 16'h8000, 16'hA000, 16'hC000
    };

    // Command signals from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic load_out;
    } cmd_t;

    // Alignment mask of each memory type; unknown types give zero.
    function automatic logic [ALIGN_W-1:0] type_align(input logic [TYPE_W-1:0] t);
        logic [ALIGN_W-1:0] r;
        unique case (t)
            4'd0, 4'd1: r = 14'h003f;
            4'd2:       r = 14'h00ff;
            4'd3:       r = 14'h001f;
            4'd4:       r = 14'h07ff;
            4'd5:       r = 14'h0003;
            4'd6:       r = 14'h000f;
            4'd7, 4'd8, 4'd9, 4'd10, 4'd11: r = 14'h0fff;
            default:    r = '0;
        endcase
        return r;
    endfunction

    // Smallest ladder pitch at or above the request; any request above the last step gives PITCH_TOP.
    function automatic logic [PITCH_W-1:0] round_pitch(input logic [PITCH_W-1:0] p);
        logic [PITCH_W-1:0] r;
        r = PITCH_TOP;
        for (int k = LADDER_N - 1; k >= 0; k--)
        begin
            if (p <= PITCH_LADDER[k])
            begin
                r = PITCH_LADDER[k];
            end
        end
        return r;
    endfunction

endpackage

/* sv/tra_ctrl.sv */
// Controller state machine of the tile region allocator: handshakes and sequencing.
module tra_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    output tra_pkg::cmd_t cmd
);
    import tra_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_BUSY = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic accept, out_xfer, load_out;

    // Handshake decode.
    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign out_xfer = out_valid_reg && !out_stall;
    assign load_out = (state_reg == ST_BUSY) && (!out_valid_reg || out_xfer);

    assign in_stall     = (state_reg == ST_BUSY);
    assign out_valid    = out_valid_reg;
    assign cmd.capture  = accept;
    assign cmd.load_out = load_out;

    // Next state: a captured item finishes once the output register is free.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output valid rises on a load and falls on a transfer.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A load always leaves a result presented.
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg)
        else $error("result not presented after load");

    // A pending item waits while the presented result is held.
    a_busy_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BUSY && out_valid_reg && out_stall) |=> (state_reg == ST_BUSY))
        else $error("pending item lost while output held");

    // A transfer with nothing pending empties the output.
    a_xfer_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && state_reg == ST_IDLE) |=> !out_valid_reg)
        else $error("result repeated after transfer");

    // An accepted item blocks further input for the next cycle.
    a_capture_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("input not stalled after capture");

endmodule

/* sv/tra_dpath.sv */
// Datapath of the tile region allocator: region bitmap, pitch rounding and size multiply.
module tra_dpath #(
    parameter int TILE_REGIONS = tra_pkg::TILE_REGIONS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tra_pkg::cmd_t                   cmd,
    input  logic [tra_pkg::OP_W-1:0]        operation,
    input  logic [tra_pkg::TYPE_W-1:0]      mem_type,
    input  logic [tra_pkg::PITCH_W-1:0]     req_pitch,
    input  logic [tra_pkg::HEIGHT_W-1:0]    height,
    input  logic                            no_pitch_adjust,
    input  logic [tra_pkg::MASK_W-1:0]      res_mask,
    input  logic [tra_pkg::ADDR_W-1:0]      base_offset,
    input  logic [tra_pkg::ADDR_W-1:0]      bind_size,
    output logic [tra_pkg::STATUS_W-1:0]    status,
    output logic [tra_pkg::ALIGN_W-1:0]     align_mask,
    output logic [tra_pkg::PITCH_W-1:0]     pitch_out,
    output logic [tra_pkg::SIZE_W-1:0]      size_out,
    output logic [tra_pkg::MASK_W-1:0]      res_id,
    output logic [tra_pkg::ACTION_W-1:0]    tile_action,
    output logic [tra_pkg::TIDX_W-1:0]      tile_index,
    output logic [tra_pkg::ADDR_W-1:0]      tile_base,
    output logic [tra_pkg::ADDR_W-1:0]      tile_limit
);
    import tra_pkg::*;

    localparam int IDX_W = (TILE_REGIONS > 1) ? $clog2(TILE_REGIONS) : 1;

    // Region bitmap.
    logic [TILE_REGIONS-1:0] used_reg, used_next;

    // Working registers of the captured item.
    logic [STATUS_W-1:0] w_status_reg, w_status_next;
    logic [ALIGN_W-1:0]  w_align_reg, w_align_next;
    logic [PITCH_W-1:0]  w_pitch_reg, w_pitch_next;
    logic [PITCH_W-1:0]  w_mul_reg, w_mul_next;
    logic [HBLK_W-1:0]   w_hblk_reg, w_hblk_next;
    logic [MASK_W-1:0]   w_rid_reg, w_rid_next;
    logic [ACTION_W-1:0] w_act_reg, w_act_next;
    logic [TIDX_W-1:0]   w_tidx_reg, w_tidx_next;
    logic [ADDR_W-1:0]   w_base_reg, w_base_next;
    logic [ADDR_W-1:0]   w_limit_reg, w_limit_next;

    // Output registers.
    logic [STATUS_W-1:0] o_status_reg;
    logic [ALIGN_W-1:0]  o_align_reg;
    logic [PITCH_W-1:0]  o_pitch_reg;
    logic [SIZE_W-1:0]   o_size_reg, o_size_next;
    logic [MASK_W-1:0]   o_rid_reg;
    logic [ACTION_W-1:0] o_act_reg;
    logic [TIDX_W-1:0]   o_tidx_reg;
    logic [ADDR_W-1:0]   o_base_reg;
    logic [ADDR_W-1:0]   o_limit_reg;

    logic                    free_any;
    logic [IDX_W-1:0]        free_idx;
    logic [TILE_REGIONS-1:0] free_bit;
    logic                    mask_hit;
    logic [TIDX_W-1:0]       mask_idx;
    logic [TILE_REGIONS-1:0] mask_ext;
    logic                    bind_ok;
    logic                    misaligned;
    logic [PITCH_W-1:0]      rp;
    logic [PROD_W-1:0]       prod;

    // Lowest free region.
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = TILE_REGIONS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    assign free_bit = TILE_REGIONS'(1) << free_idx;

    // Lowest mask bit that names an existing region.
    always_comb
    begin
        mask_hit = 1'b0;
        mask_idx = '0;
        for (int i = MASK_W - 1; i >= 0; i--)
        begin
            if (res_mask[i] && (i < TILE_REGIONS))
            begin
                mask_hit = 1'b1;
                mask_idx = TIDX_W'(i);
            end
        end
    end

    assign mask_ext   = TILE_REGIONS'(res_mask);
    assign bind_ok    = $onehot(res_mask) && mask_hit;
    assign misaligned = (base_offset[ALIGN_W-1:0] != '0) || (bind_size[ALIGN_W-1:0] != '0);
    assign rp         = round_pitch(req_pitch);

    // Decode of one request into its result and the new bitmap.
    always_comb
    begin
        used_next     = used_reg;
        w_status_next = STAT_OK;
        w_align_next  = '0;
        w_pitch_next  = req_pitch;
        w_mul_next    = '0;
        w_rid_next    = '0;
        w_act_next    = ACT_NONE;
        w_tidx_next   = '0;
        w_base_next   = '0;
        w_limit_next  = '0;
        w_hblk_next   = HBLK_W'((HEIGHT_W'(height) + (HEIGHT_W+1)'(31)) >> HBLK_SHIFT);
        unique case (operation)
            OP_ALLOC:
            begin
                if (mem_type >= NUM_TYPES)
                begin
                    w_status_next = STAT_BADARG;
                end
                else
                begin
                    w_align_next = type_align(mem_type);
                    if (req_pitch != '0)
                    begin
                        if (!free_any)
                        begin
                            w_status_next = STAT_NOFREE;
                        end
                        else if (!(no_pitch_adjust && (rp != req_pitch)))
                        begin
                            used_next    = used_reg | free_bit;
                            w_align_next = ALIGN_TILED;
                            w_pitch_next = rp;
                            w_mul_next   = rp;
                            w_rid_next   = MASK_W'(1) << free_idx;
                        end
                    end
                end
            end
            OP_FREE:
            begin
                if (mask_hit)
                begin
                    w_act_next  = ACT_INVAL;
                    w_tidx_next = mask_idx;
                end
                used_next = used_reg & ~mask_ext;
            end
            OP_BIND:
            begin
                if (res_mask != '0)
                begin
                    if (!bind_ok)
                    begin
                        w_status_next = STAT_BADARG;
                    end
                    else if (misaligned)
                    begin
                        used_next   = used_reg & ~mask_ext;
                        w_act_next  = ACT_INVAL;
                        w_tidx_next = mask_idx;
                    end
                    else
                    begin
                        w_act_next   = ACT_PROG;
                        w_tidx_next  = mask_idx;
                        w_base_next  = base_offset;
                        w_limit_next = base_offset + bind_size - ADDR_W'(1);
                    end
                end
            end
            default:
            begin
                w_status_next = STAT_BADARG;
            end
        endcase
    end

    // Size is the rounded pitch times the height rounded up to 32 lines; it is zero unless a region was allocated.
    assign prod        = w_mul_reg * w_hblk_reg;
    assign o_size_next = SIZE_W'({prod, HBLK_SHIFT'(0)});

    // Region bitmap register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (cmd.capture)
        begin
            used_reg <= used_next;
        end
    end

    // Working registers, loaded on an input transfer.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            w_status_reg <= w_status_next;
            w_align_reg  <= w_align_next;
            w_pitch_reg  <= w_pitch_next;
            w_mul_reg    <= w_mul_next;
            w_hblk_reg   <= w_hblk_next;
            w_rid_reg    <= w_rid_next;
            w_act_reg    <= w_act_next;
            w_tidx_reg   <= w_tidx_next;
            w_base_reg   <= w_base_next;
            w_limit_reg  <= w_limit_next;
        end
    end

    // Output registers, loaded when the controller finishes an item.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            o_status_reg <= w_status_reg;
            o_align_reg  <= w_align_reg;
            o_pitch_reg  <= w_pitch_reg;
            o_size_reg   <= o_size_next;
            o_rid_reg    <= w_rid_reg;
            o_act_reg    <= w_act_reg;
            o_tidx_reg   <= w_tidx_reg;
            o_base_reg   <= w_base_reg;
            o_limit_reg  <= w_limit_reg;
        end
    end

    assign status      = o_status_reg;
    assign align_mask  = o_align_reg;
    assign pitch_out   = o_pitch_reg;
    assign size_out    = o_size_reg;
    assign res_id      = o_rid_reg;
    assign tile_action = o_act_reg;
    assign tile_index  = o_tidx_reg;
    assign tile_base   = o_base_reg;
    assign tile_limit  = o_limit_reg;

endmodule

/* sv/tile_region_allocator.sv */
// Top level of the tile region allocator: controller and datapath joined by commands.
//
// Each transfer carries one request (allocate, free or bind) and produces exactly one
// result. In the transfer cycle the region bitmap is searched, the pitch is rounded up
// the tile pitch ladder, the bind limit is added and the bitmap is updated; the rest is
// held in the working registers. From these the pitch is multiplied by the height in
// 32-line blocks and the result is loaded into the output register once it is free.
// The input stalls from the transfer until that load, so a new request is taken only
// after the last has been loaded. A result waiting in the output register does not
// block the next request; that request then waits in its working registers until the
// output transfers. Reset is asynchronous and active low and leaves all regions free.
module tile_region_allocator #(
    parameter int TILE_REGIONS = tra_pkg::TILE_REGIONS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [tra_pkg::OP_W-1:0]        operation,
    input  logic [tra_pkg::TYPE_W-1:0]      mem_type,
    input  logic [tra_pkg::PITCH_W-1:0]     req_pitch,
    input  logic [tra_pkg::HEIGHT_W-1:0]    height,
    input  logic                            no_pitch_adjust,
    input  logic [tra_pkg::MASK_W-1:0]      res_mask,
    input  logic [tra_pkg::ADDR_W-1:0]      base_offset,
    input  logic [tra_pkg::ADDR_W-1:0]      bind_size,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [tra_pkg::STATUS_W-1:0]    status,
    output logic [tra_pkg::ALIGN_W-1:0]     align_mask,
    output logic [tra_pkg::PITCH_W-1:0]     pitch_out,
    output logic [tra_pkg::SIZE_W-1:0]      size_out,
    output logic [tra_pkg::MASK_W-1:0]      res_id,
    output logic [tra_pkg::ACTION_W-1:0]    tile_action,
    output logic [tra_pkg::TIDX_W-1:0]      tile_index,
    output logic [tra_pkg::ADDR_W-1:0]      tile_base,
    output logic [tra_pkg::ADDR_W-1:0]      tile_limit
);
    import tra_pkg::*;

    cmd_t cmd;

    // Sequencing and handshakes.
    tra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // Bitmap, rounding and result registers.
    tra_dpath #(
        .TILE_REGIONS (TILE_REGIONS)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .operation       (operation),
        .mem_type        (mem_type),
        .req_pitch       (req_pitch),
        .height          (height),
        .no_pitch_adjust (no_pitch_adjust),
        .res_mask        (res_mask),
        .base_offset     (base_offset),
        .bind_size       (bind_size),
        .status          (status),
        .align_mask      (align_mask),
        .pitch_out       (pitch_out),
        .size_out        (size_out),
        .res_id          (res_id),
        .tile_action     (tile_action),
        .tile_index      (tile_index),
        .tile_base       (tile_base),
        .tile_limit      (tile_limit)
    );

endmodule
